// ----- rtl/polyphonic_step_sequencer_macros.svh -----
// Assertion macros shared by the step sequencer RTL.
// Each macro expects clock and reset to be visible in the calling module.
`ifndef POLYPHONIC_STEP_SEQUENCER_MACROS_SVH
`define POLYPHONIC_STEP_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define PSS_ASSERT_HOLD(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/psseq_pkg.sv -----
// Shared types, constants and codes of the polyphonic step sequencer.
// No dependencies; imported by every other RTL file except psseq_ram.
`default_nettype none
package psseq_pkg;

   localparam int VOICES    = 4;
   localparam int STEPS     = 32;
   localparam int PATTERNS  = 16;
   localparam int VOICE_W   = $clog2(VOICES);
   localparam int STEP_W    = $clog2(STEPS);
   localparam int PAT_W     = $clog2(PATTERNS);
   localparam int ROW_AW    = PAT_W + STEP_W;
   localparam int ROW_DEPTH = PATTERNS * STEPS;
   localparam int CELL_W    = 8;
   localparam int ROW_W     = VOICES * CELL_W;
   localparam int EV_DEPTH  = VOICES + 1;
   localparam int EV_W      = $clog2(EV_DEPTH + 1);
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CELL_W-1:0] CELL_EMPTY = 8'h80;
   localparam logic [CELL_W-1:0] CELL_TIE   = 8'h81;
   localparam logic [CELL_W-1:0] NONE_HELD  = 8'h80;

   localparam logic [15:0] HALF_STEP_RESET = 16'(300000 / (1200 * 2));
   localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
   localparam logic [6:0]  BASE_NOTE_RESET = 7'd48;
   localparam logic [15:0] PULSE_MIN_MS    = 16'd20;
   localparam logic [2:0]  MIDI_DIV_RELOAD = 3'd5;
   localparam logic [15:0] LAMP_HOLD_MS    = 16'd125;
   localparam logic [15:0] SAVE_HOLD_MS    = 16'd1000;
   localparam logic [6:0]  NOTE_MAX        = 7'd127;

   localparam int LAMP_PLAY = 0;
   localparam int LAMP_REC  = 1;
   localparam int LAMP_TAP  = 2;
   localparam int LAMP_SAVE = 3;

   typedef logic [VOICES-1:0][CELL_W-1:0] row_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CLOCK_TIMEOUT = 1'b0,
      REG_BASE_NOTE     = 1'b1
   } csr_reg_type;

   typedef enum logic [3:0] {
      MODE_TICK      = 4'd0,
      MODE_MCLK      = 4'd1,
      MODE_START     = 4'd2,
      MODE_CONT      = 4'd3,
      MODE_STOP      = 4'd4,
      MODE_EPULSE    = 4'd5,
      MODE_ESTART    = 4'd6,
      MODE_NOTE_ON   = 4'd7,
      MODE_NOTE_OFF  = 4'd8,
      MODE_SAVE      = 4'd9,
      MODE_TAP       = 4'd10,
      MODE_REC       = 4'd11,
      MODE_PLAY      = 4'd12,
      MODE_SELECT    = 4'd13
   } mode_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_TICK, OP_MCLK, OP_START, OP_CONT, OP_STOP, OP_EPULSE,
      OP_ESTART, OP_NOTE_ON, OP_NOTE_OFF, OP_SAVE, OP_TAP, OP_REC, OP_PLAY,
      OP_SELECT
   } op_type;

   typedef enum logic [1:0] {
      RUN_RESET = 2'd0,
      RUN_PLAY  = 2'd1,
      RUN_REC   = 2'd2
   } run_type;

   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_ON      = 2'd1,
      KIND_OFF     = 2'd2,
      KIND_ALL_OFF = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_EXEC, ST_TICK_TO, ST_TICK_LAMP, ST_TICK_TAP,
      ST_PT_GATE, ST_PT_LEN, ST_PT_MOD, ST_PT_RDCUR, ST_PT_RDNXT, ST_PT_VOICE,
      ST_PT_END, ST_REC_CLR, ST_INS_RD, ST_INS_WR, ST_OFF_RD, ST_OFF_CHK,
      ST_ADVANCE, ST_EMIT
   } state_type;

   typedef struct packed {
      op_type           op;
      logic [6:0]       note;
      logic [PAT_W-1:0] sel;
   } queue_item_type;

   typedef struct packed {
      logic pop;
      logic busy;
   } back_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/polyphonic_step_sequencer.sv -----
// Polyphonic step sequencer: 4 voices, 16 patterns of 32 steps, tap/MIDI/external clock.
// A step tick runs a modulo loop, two pattern RAM reads and a pass over each voice before its
// results; a first recorded note first clears the 32-row pattern. One request at a time,
// then one result item per cycle while rsp_ready allows; a 2-deep queue takes more.
// After reset all 512 rows of the pattern RAM are cleared; req_ready stays low meanwhile.
`default_nettype none
module polyphonic_step_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [3:0]                      req_mode,
   input  logic [6:0]                      req_note_number,
   input  logic [psseq_pkg::PAT_W-1:0]     req_pattern_select,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_event_kind,
   output logic [6:0]                      rsp_event_note,
   output logic                            rsp_last_of_run,
   output logic [1:0]                      rsp_run_state,
   output logic [3:0]                      rsp_lamp_flags,
   output logic [3:0]                      rsp_queued_pattern,
   input  logic                            csr_write_en,
   input  logic [psseq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [psseq_pkg::CSR_W-1:0]     csr_write_data
);
   import psseq_pkg::*;

   back_ctrl_type  ctrl;
   queue_item_type q_item;
   logic           q_valid;

   psseq_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_note_number    (req_note_number),
      .req_pattern_select (req_pattern_select),
      .ctrl               (ctrl),
      .q_valid            (q_valid),
      .q_item             (q_item)
   );

   psseq_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .ctrl               (ctrl),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_event_note     (rsp_event_note),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_run_state      (rsp_run_state),
      .rsp_lamp_flags     (rsp_lamp_flags),
      .rsp_queued_pattern (rsp_queued_pattern)
   );

endmodule
`default_nettype wire

// ----- rtl/psseq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module psseq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512,
   localparam int AW  = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/psseq_front.sv -----
// Front end: accepts request transactions, decodes the mode into an operation
// and holds them in a short queue for the back end. Uses psseq_pkg.
`default_nettype none
module psseq_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [3:0]                     req_mode,
   input  logic [6:0]                     req_note_number,
   input  logic [psseq_pkg::PAT_W-1:0]    req_pattern_select,
   input  psseq_pkg::back_ctrl_type       ctrl,
   output logic                           q_valid,
   output psseq_pkg::queue_item_type      q_item
);
   import psseq_pkg::*;

   queue_item_type    slot_ff [QDEPTH];
   queue_item_type    dec_item;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;

   always_comb begin
      dec_item.note = req_note_number;
      dec_item.sel  = req_pattern_select;
      unique case (mode_type'(req_mode))
         MODE_TICK:     dec_item.op = OP_TICK;
         MODE_MCLK:     dec_item.op = OP_MCLK;
         MODE_START:    dec_item.op = OP_START;
         MODE_CONT:     dec_item.op = OP_CONT;
         MODE_STOP:     dec_item.op = OP_STOP;
         MODE_EPULSE:   dec_item.op = OP_EPULSE;
         MODE_ESTART:   dec_item.op = OP_ESTART;
         MODE_NOTE_ON:  dec_item.op = OP_NOTE_ON;
         MODE_NOTE_OFF: dec_item.op = OP_NOTE_OFF;
         MODE_SAVE:     dec_item.op = OP_SAVE;
         MODE_TAP:      dec_item.op = OP_TAP;
         MODE_REC:      dec_item.op = OP_REC;
         MODE_PLAY:     dec_item.op = OP_PLAY;
         MODE_SELECT:   dec_item.op = OP_SELECT;
         default:       dec_item.op = OP_NONE;
      endcase
   end

   assign req_ready = (count_ff < (QPTR_W + 1)'(QDEPTH)) && !ctrl.busy;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = ctrl.pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (QPTR_W + 1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec_item;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/psseq_back.sv -----
// Back end: runs each queued operation through a sequencer over the clock,
// tempo and pattern state, buffers events and drives the response register.
// Uses psseq_pkg, psseq_ram and the assertion macro header.
`default_nettype none
`include "polyphonic_step_sequencer_macros.svh"
module psseq_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  psseq_pkg::queue_item_type      q_item,
   output psseq_pkg::back_ctrl_type       ctrl,
   input  logic                           csr_write_en,
   input  logic [psseq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [psseq_pkg::CSR_W-1:0]    csr_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_event_kind,
   output logic [6:0]                     rsp_event_note,
   output logic                           rsp_last_of_run,
   output logic [1:0]                     rsp_run_state,
   output logic [3:0]                     rsp_lamp_flags,
   output logic [3:0]                     rsp_queued_pattern
);
   import psseq_pkg::*;

   state_type        state_ff, state_in;
   queue_item_type   cur_ff, cur_in;
   logic [15:0]      tmo_ff, tmo_in;
   logic [6:0]       base_ff, base_in;
   logic [15:0]      now_ff, now_in;
   run_type          run_ff, run_in;
   logic [15:0]      hsp_ff, hsp_in, pll_ff, pll_in, stamp_ff, stamp_in;
   logic [15:0]      seen_ff, seen_in, cnt_ff, cnt_in, epulse_ff, epulse_in;
   logic [PAT_W-1:0] act_ff, act_in, nxt_pat_ff, nxt_pat_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             half_ff, half_in, clrp_ff, clrp_in;
   logic [6:0]       root_ff, root_in;
   logic             ext_ff, ext_in, midi_ff, midi_in;
   logic [2:0]       div_ff, div_in;
   logic [15:0]      tap_t_ff [3];
   logic [15:0]      tap_t_in [3];
   logic [1:0]       tap_cnt_ff, tap_cnt_in;
   logic [CELL_W-1:0] held_ff [VOICES];
   logic [CELL_W-1:0] held_in [VOICES];
   logic [15:0]      lamp_st_ff [4];
   logic [15:0]      lamp_st_in [4];
   logic [3:0]       lamps_ff, lamps_in, flash_mask;
   logic [6:0]       roots_ff [PATTERNS];
   logic [6:0]       roots_in [PATTERNS];
   logic [STEP_W-1:0] lens_ff [PATTERNS];
   logic [STEP_W-1:0] lens_in [PATTERNS];
   logic [ROW_AW-1:0] clr_ff, clr_in;
   logic [STEP_W:0]  mod_ff, mod_in;
   logic [VOICE_W-1:0] voice_ff, voice_in;
   logic [EV_W-1:0]  ev_cnt_ff, ev_cnt_in, emit_k_ff, emit_k_in;
   logic             rsp_valid_ff, rsp_valid_in;

   row_type          cur_row_ff;
   kind_type         ev_kind_ff [EV_DEPTH];
   logic [6:0]       ev_note_ff [EV_DEPTH];
   kind_type         out_kind;
   logic [6:0]       out_note;
   logic             out_last, out_load, out_free;
   logic [1:0]       rsp_kind_ff;
   logic [6:0]       rsp_note_ff;
   logic             rsp_last_ff;
   logic [1:0]       rsp_run_ff;
   logic [3:0]       rsp_lamps_ff, rsp_pat_ff;

   logic             push_en;
   kind_type         push_kind;
   logic [6:0]       push_note;
   logic             ram_we, ram_re;
   logic [ROW_AW-1:0] ram_waddr, ram_raddr;
   row_type          ram_wdata, ram_rdata;

   logic [15:0]      since_stamp, pulse_gap, d1, d2, tap_gap;
   logic [STEP_W-1:0] len_cur;
   logic [6:0]       proot;
   logic [1:0]       tc0;
   logic [CELL_W-1:0] c_cell, n_cell, code;
   logic signed [8:0] shifted;
   logic [6:0]       clamped;
   logic             fire, ins_found, all_free, q_pop;
   row_type          ins_row;

   psseq_ram #(.WIDTH(ROW_W), .DEPTH(ROW_DEPTH)) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign since_stamp = now_ff - stamp_ff;
   assign pulse_gap   = now_ff - epulse_ff;
   assign d1          = tap_t_ff[1] - tap_t_ff[0];
   assign d2          = now_ff - tap_t_ff[1];
   assign tap_gap     = now_ff - tap_t_ff[tap_cnt_ff - 2'd1];
   assign len_cur     = lens_ff[act_ff];
   assign proot       = roots_ff[act_ff];
   assign tc0         = (tap_cnt_ff > 2'd2) ? 2'd0 : tap_cnt_ff;
   assign c_cell      = cur_row_ff[voice_ff];
   assign n_cell      = ram_rdata[voice_ff];
   assign shifted     = $signed({2'b00, c_cell[6:0]}) + $signed({2'b00, root_ff})
                      - $signed({2'b00, proot});
   assign clamped     = (shifted < 0) ? 7'd0 :
                        (shifted > $signed({2'b00, NOTE_MAX})) ? NOTE_MAX : shifted[6:0];
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (cur_ff.op)
         OP_SAVE: code = CELL_EMPTY;
         OP_TAP:  code = CELL_TIE;
         default: code = {1'b0, cur_ff.note};
      endcase
      ins_found = 1'b0;
      ins_row   = ram_rdata;
      if (code[7]) begin
         ins_row = {VOICES{code}};
      end else begin
         for (int v = 0; v < VOICES; v++) begin
            if (!ins_found && ram_rdata[v] == CELL_EMPTY) begin
               ins_row[v] = code;
               ins_found  = 1'b1;
            end
         end
      end
      all_free = 1'b1;
      for (int v = 0; v < VOICES; v++) begin
         all_free = all_free && held_ff[v][7];
      end
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      tmo_in      = tmo_ff;
      base_in     = base_ff;
      now_in      = now_ff;
      run_in      = run_ff;
      hsp_in      = hsp_ff;
      pll_in      = pll_ff;
      stamp_in    = stamp_ff;
      seen_in     = seen_ff;
      cnt_in      = cnt_ff;
      epulse_in   = epulse_ff;
      act_in      = act_ff;
      nxt_pat_in  = nxt_pat_ff;
      step_in     = step_ff;
      half_in     = half_ff;
      clrp_in     = clrp_ff;
      root_in     = root_ff;
      ext_in      = ext_ff;
      midi_in     = midi_ff;
      div_in      = div_ff;
      tap_t_in    = tap_t_ff;
      tap_cnt_in  = tap_cnt_ff;
      held_in     = held_ff;
      lamp_st_in  = lamp_st_ff;
      lamps_in    = lamps_ff;
      roots_in    = roots_ff;
      lens_in     = lens_ff;
      clr_in      = clr_ff;
      mod_in      = mod_ff;
      voice_in    = voice_ff;
      ev_cnt_in   = ev_cnt_ff;
      emit_k_in   = emit_k_ff;
      flash_mask  = 4'b0000;
      push_en     = 1'b0;
      push_kind   = KIND_STATUS;
      push_note   = 7'd0;
      ram_we      = 1'b0;
      ram_waddr   = clr_ff;
      ram_wdata   = {VOICES{CELL_EMPTY}};
      ram_re      = 1'b0;
      ram_raddr   = {act_ff, step_ff};
      q_pop       = 1'b0;
      out_load    = 1'b0;
      out_kind    = KIND_STATUS;
      out_note    = 7'd0;
      out_last    = 1'b0;
      fire        = 1'b0;

      if (csr_write_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_CLOCK_TIMEOUT: tmo_in  = csr_write_data;
            REG_BASE_NOTE:     base_in = csr_write_data[6:0];
            default:           tmo_in  = tmo_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + ROW_AW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_EMIT;
            unique case (cur_ff.op)
               OP_TICK: begin
                  now_in   = now_ff + 16'd1;
                  state_in = ST_TICK_TO;
               end
               OP_MCLK: begin
                  if (!ext_ff && midi_ff) begin
                     if (div_ff != 3'd0) begin
                        div_in = div_ff - 3'd1;
                     end else begin
                        div_in = MIDI_DIV_RELOAD;
                        cnt_in = cnt_ff + 16'd1;
                     end
                  end
               end
               OP_START: begin
                  midi_in  = 1'b1;
                  div_in   = 3'd0;
                  cnt_in   = 16'd0;
                  step_in  = '0;
                  half_in  = 1'b0;
                  seen_in  = 16'd0;
                  stamp_in = now_ff;
                  run_in   = RUN_PLAY;
               end
               OP_CONT: begin
                  midi_in = 1'b1;
                  run_in  = RUN_PLAY;
               end
               OP_STOP: begin
                  midi_in   = 1'b0;
                  run_in    = RUN_RESET;
                  push_en   = 1'b1;
                  push_kind = KIND_ALL_OFF;
                  for (int v = 0; v < VOICES; v++) held_in[v] = NONE_HELD;
               end
               OP_EPULSE: begin
                  if (!ext_ff) begin
                     epulse_in = now_ff;
                     cnt_in    = 16'd1;
                     ext_in    = 1'b1;
                  end else if (pulse_gap >= PULSE_MIN_MS) begin
                     epulse_in = now_ff;
                     pll_in    = pulse_gap >> 1;
                     cnt_in    = cnt_ff + 16'd1;
                  end
               end
               OP_ESTART: begin
                  step_in  = '0;
                  half_in  = 1'b0;
                  seen_in  = cnt_ff;
                  stamp_in = now_ff;
                  run_in   = RUN_PLAY;
               end
               OP_NOTE_ON: begin
                  unique case (run_ff)
                     RUN_RESET: begin
                        flash_mask[LAMP_PLAY] = 1'b1;
                        push_en   = 1'b1;
                        push_kind = KIND_ON;
                        push_note = cur_ff.note;
                     end
                     RUN_PLAY: begin
                        flash_mask[LAMP_PLAY] = 1'b1;
                        root_in = cur_ff.note;
                     end
                     RUN_REC: begin
                        flash_mask[LAMP_REC] = 1'b1;
                        clrp_in  = 1'b0;
                        state_in = clrp_ff ? ST_REC_CLR : ST_INS_RD;
                     end
                     default: run_in = run_ff;
                  endcase
               end
               OP_NOTE_OFF: begin
                  if (run_ff == RUN_RESET) begin
                     push_en   = 1'b1;
                     push_kind = KIND_OFF;
                     push_note = cur_ff.note;
                  end else if (run_ff == RUN_REC) begin
                     state_in = ST_OFF_RD;
                  end
               end
               OP_SAVE: begin
                  if (run_ff == RUN_RESET) begin
                     if (!lamps_ff[LAMP_SAVE]) flash_mask[LAMP_SAVE] = 1'b1;
                  end else if (run_ff == RUN_REC) begin
                     state_in = ST_INS_RD;
                  end
               end
               OP_TAP: begin
                  if (run_ff == RUN_PLAY) begin
                     tap_t_in[tc0] = now_ff;
                     if (tc0 == 2'd2) begin
                        tap_cnt_in = 2'd0;
                        hsp_in     = 16'((17'(d1) + 17'(d2)) >> 3);
                        stamp_in   = now_ff;
                     end else begin
                        tap_cnt_in = tc0 + 2'd1;
                     end
                  end else if (run_ff == RUN_REC) begin
                     state_in = ST_INS_RD;
                  end
               end
               OP_REC: begin
                  push_en   = 1'b1;
                  push_kind = KIND_ALL_OFF;
                  for (int v = 0; v < VOICES; v++) held_in[v] = NONE_HELD;
                  step_in = '0;
                  if (run_ff == RUN_REC) begin
                     run_in = RUN_RESET;
                  end else begin
                     clrp_in = 1'b1;
                     run_in  = RUN_REC;
                  end
               end
               OP_PLAY: begin
                  push_en   = 1'b1;
                  push_kind = KIND_ALL_OFF;
                  for (int v = 0; v < VOICES; v++) held_in[v] = NONE_HELD;
                  if (run_ff == RUN_PLAY) begin
                     run_in = RUN_RESET;
                  end else begin
                     pll_in   = 16'd0;
                     stamp_in = now_ff - hsp_ff;
                     seen_in  = cnt_ff;
                     step_in  = '0;
                     half_in  = 1'b0;
                     root_in  = proot;
                     run_in   = RUN_PLAY;
                  end
               end
               OP_SELECT: begin
                  nxt_pat_in = cur_ff.sel;
                  if (run_ff == RUN_RESET) act_in = cur_ff.sel;
               end
               default: state_in = ST_EMIT;
            endcase
         end
         ST_TICK_TO: begin
            if ((ext_ff || midi_ff) && since_stamp > tmo_ff) begin
               push_en   = 1'b1;
               push_kind = KIND_ALL_OFF;
               for (int v = 0; v < VOICES; v++) held_in[v] = NONE_HELD;
               midi_in = 1'b0;
               ext_in  = 1'b0;
               run_in  = RUN_RESET;
            end
            state_in = ST_TICK_LAMP;
         end
         ST_TICK_LAMP: begin
            for (int i = 0; i < 4; i++) begin
               if (lamps_ff[i] && (now_ff - lamp_st_ff[i]) >
                   ((i == LAMP_SAVE) ? SAVE_HOLD_MS : LAMP_HOLD_MS)) begin
                  lamps_in[i] = 1'b0;
               end
            end
            state_in = ST_TICK_TAP;
         end
         ST_TICK_TAP: begin
            if (tap_cnt_ff != 2'd0 && tap_gap >= tmo_ff) tap_cnt_in = 2'd0;
            state_in = ST_PT_GATE;
         end
         ST_PT_GATE: begin
            if (ext_ff) begin
               fire = (seen_ff != cnt_ff) || (half_ff && !(since_stamp < pll_ff));
               if (seen_ff != cnt_ff) flash_mask[LAMP_TAP] = 1'b1;
            end else if (midi_ff) begin
               fire = (seen_ff != cnt_ff);
               if (fire && cnt_ff[0]) flash_mask[LAMP_TAP] = 1'b1;
            end else begin
               fire = !(since_stamp < hsp_ff);
            end
            state_in = ST_EMIT;
            if (fire) begin
               stamp_in = now_ff;
               seen_in  = cnt_ff;
               if (run_ff == RUN_PLAY) begin
                  if (step_ff == '0 && !half_ff) act_in = nxt_pat_ff;
                  state_in = ST_PT_LEN;
               end
            end
         end
         ST_PT_LEN: begin
            mod_in   = {1'b0, step_ff} + (STEP_W + 1)'(1);
            state_in = (len_cur == '0) ? ST_EMIT : ST_PT_MOD;
         end
         ST_PT_MOD: begin
            if (mod_ff >= {1'b0, len_cur}) begin
               mod_in = mod_ff - {1'b0, len_cur};
            end else begin
               state_in = ST_PT_RDCUR;
            end
         end
         ST_PT_RDCUR: begin
            ram_re   = 1'b1;
            state_in = ST_PT_RDNXT;
         end
         ST_PT_RDNXT: begin
            ram_re    = 1'b1;
            ram_raddr = {act_ff, mod_ff[STEP_W-1:0]};
            voice_in  = '0;
            state_in  = ST_PT_VOICE;
         end
         ST_PT_VOICE: begin
            if (c_cell == CELL_EMPTY || (half_ff && n_cell != CELL_TIE)) begin
               if (!held_ff[voice_ff][7]) begin
                  push_en   = 1'b1;
                  push_kind = KIND_OFF;
                  push_note = held_ff[voice_ff][6:0];
               end
               held_in[voice_ff] = NONE_HELD;
            end else if (!half_ff && !c_cell[7]) begin
               push_en   = 1'b1;
               push_kind = KIND_ON;
               push_note = clamped;
               held_in[voice_ff] = {1'b0, clamped};
            end
            voice_in = voice_ff + VOICE_W'(1);
            if (voice_ff == VOICE_W'(VOICES - 1)) state_in = ST_PT_END;
         end
         ST_PT_END: begin
            if (half_ff) begin
               step_in = mod_ff[STEP_W-1:0];
            end else begin
               flash_mask[LAMP_TAP] = 1'b1;
            end
            half_in  = !half_ff;
            state_in = ST_EMIT;
         end
         ST_REC_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = {act_ff, clr_ff[STEP_W-1:0]};
            clr_in    = clr_ff + ROW_AW'(1);
            if (clr_ff[STEP_W-1:0] == '1) begin
               clr_in          = '0;
               roots_in[act_ff] = base_ff;
               lens_in[act_ff]  = '0;
               state_in         = ST_INS_RD;
            end
         end
         ST_INS_RD: begin
            ram_re    = 1'b1;
            ram_raddr = {act_ff, len_cur};
            state_in  = ST_INS_WR;
         end
         ST_INS_WR: begin
            ram_we    = 1'b1;
            ram_waddr = {act_ff, len_cur};
            ram_wdata = ins_row;
            if (len_cur == '0) roots_in[act_ff] = code[7] ? base_ff : code[6:0];
            if (cur_ff.op == OP_NOTE_ON) begin
               push_en   = 1'b1;
               push_kind = KIND_ON;
               push_note = cur_ff.note;
               state_in  = ST_EMIT;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_OFF_RD: begin
            ram_re    = 1'b1;
            ram_raddr = {act_ff, len_cur};
            state_in  = ST_OFF_CHK;
         end
         ST_OFF_CHK: begin
            state_in = (ram_rdata[0] == {1'b0, cur_ff.note}) ? ST_ADVANCE : ST_EMIT;
         end
         ST_ADVANCE: begin
            push_en   = 1'b1;
            push_kind = KIND_ALL_OFF;
            for (int v = 0; v < VOICES; v++) held_in[v] = NONE_HELD;
            if (len_cur < STEP_W'(STEPS - 1)) begin
               lens_in[act_ff] = len_cur + STEP_W'(1);
            end else begin
               step_in = '0;
               half_in = 1'b0;
               run_in  = RUN_PLAY;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (emit_k_ff < ev_cnt_ff) begin
                  out_kind  = ev_kind_ff[emit_k_ff];
                  out_note  = ev_note_ff[emit_k_ff];
                  emit_k_in = emit_k_ff + EV_W'(1);
               end else begin
                  out_last  = 1'b1;
                  emit_k_in = '0;
                  ev_cnt_in = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (push_en) ev_cnt_in = ev_cnt_ff + EV_W'(1);
      for (int i = 0; i < 4; i++) begin
         if (flash_mask[i]) lamp_st_in[i] = now_ff;
      end
      lamps_in = lamps_in | flash_mask;
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         tmo_ff       <= TIMEOUT_RESET;
         base_ff      <= BASE_NOTE_RESET;
         now_ff       <= '0;
         run_ff       <= RUN_RESET;
         hsp_ff       <= HALF_STEP_RESET;
         pll_ff       <= '0;
         stamp_ff     <= '0;
         seen_ff      <= '0;
         cnt_ff       <= '0;
         epulse_ff    <= '0;
         act_ff       <= '0;
         nxt_pat_ff   <= '0;
         step_ff      <= '0;
         half_ff      <= 1'b0;
         clrp_ff      <= 1'b0;
         root_ff      <= BASE_NOTE_RESET;
         ext_ff       <= 1'b0;
         midi_ff      <= 1'b0;
         div_ff       <= '0;
         tap_t_ff     <= '{default: '0};
         tap_cnt_ff   <= '0;
         held_ff      <= '{default: NONE_HELD};
         lamp_st_ff   <= '{default: '0};
         lamps_ff     <= '0;
         roots_ff     <= '{default: BASE_NOTE_RESET};
         lens_ff      <= '{default: '0};
         clr_ff       <= '0;
         mod_ff       <= '0;
         voice_ff     <= '0;
         ev_cnt_ff    <= '0;
         emit_k_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         tmo_ff       <= tmo_in;
         base_ff      <= base_in;
         now_ff       <= now_in;
         run_ff       <= run_in;
         hsp_ff       <= hsp_in;
         pll_ff       <= pll_in;
         stamp_ff     <= stamp_in;
         seen_ff      <= seen_in;
         cnt_ff       <= cnt_in;
         epulse_ff    <= epulse_in;
         act_ff       <= act_in;
         nxt_pat_ff   <= nxt_pat_in;
         step_ff      <= step_in;
         half_ff      <= half_in;
         clrp_ff      <= clrp_in;
         root_ff      <= root_in;
         ext_ff       <= ext_in;
         midi_ff      <= midi_in;
         div_ff       <= div_in;
         tap_t_ff     <= tap_t_in;
         tap_cnt_ff   <= tap_cnt_in;
         held_ff      <= held_in;
         lamp_st_ff   <= lamp_st_in;
         lamps_ff     <= lamps_in;
         roots_ff     <= roots_in;
         lens_ff      <= lens_in;
         clr_ff       <= clr_in;
         mod_ff       <= mod_in;
         voice_ff     <= voice_in;
         ev_cnt_ff    <= ev_cnt_in;
         emit_k_ff    <= emit_k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PT_RDNXT) begin
         cur_row_ff <= ram_rdata;
      end
      if (push_en) begin
         ev_kind_ff[ev_cnt_ff] <= push_kind;
         ev_note_ff[ev_cnt_ff] <= push_note;
      end
      if (out_load) begin
         rsp_kind_ff  <= out_kind;
         rsp_note_ff  <= out_note;
         rsp_last_ff  <= out_last;
         rsp_run_ff   <= run_ff;
         rsp_lamps_ff <= lamps_ff;
         rsp_pat_ff   <= nxt_pat_ff;
      end
   end

   assign ctrl.pop           = q_pop;
   assign ctrl.busy          = (state_ff == ST_CLEAR);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_kind_ff;
   assign rsp_event_note     = rsp_note_ff;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_run_state      = rsp_run_ff;
   assign rsp_lamp_flags     = rsp_lamps_ff;
   assign rsp_queued_pattern = rsp_pat_ff;

   `PSS_ASSERT_HOLD(a_ev_bound, 1'b1, ev_cnt_ff <= EV_W'(EV_DEPTH), "event buffer overrun")
   `PSS_ASSERT_NEXT(a_adv_release, state_ff == ST_ADVANCE, all_free, "voices held after advance")
   `PSS_ASSERT_NEXT(a_run_closed, out_load && out_last, state_ff == ST_IDLE && ev_cnt_ff == '0, "status item did not close the run")
   `PSS_ASSERT_NEXT(a_voice_loop, state_ff == ST_PT_VOICE && voice_ff == VOICE_W'(VOICES - 1), state_ff == ST_PT_END, "voice sweep overran")

endmodule
`default_nettype wire

// ----- tb/sv/tb_polyphonic_step_sequencer.sv -----
// Self-checking testbench for polyphonic_step_sequencer: drives timed events, predicts
// every note/status result in a behavioral model and compares them in order.
// Depends on psseq_pkg and the polyphonic_step_sequencer RTL.
`timescale 1ns / 1ps
module tb_polyphonic_step_sequencer;
   import psseq_pkg::*;

   typedef struct {
      logic [3:0] mode;
      logic [6:0] note;
      logic [3:0] sel;
   } event_item;

   typedef struct {
      logic [1:0] kind;
      logic [6:0] note;
      logic       last;
      logic [1:0] run;
      logic [3:0] lamps;
      logic [3:0] queued;
   } seq_result;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [3:0] req_mode = 0;
   logic [6:0] req_note_number = 0;
   logic [PAT_W-1:0] req_pattern_select = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [1:0] rsp_event_kind, rsp_run_state;
   logic [6:0] rsp_event_note;
   logic rsp_last_of_run;
   logic [3:0] rsp_lamp_flags, rsp_queued_pattern;
   logic csr_write_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = REG_CLOCK_TIMEOUT;
   logic [CSR_W-1:0] csr_write_data = 0;

   polyphonic_step_sequencer dut (.*);

   always #5 clock = ~clock;

   event_item pending_events[$];
   seq_result expected_results[$];
   int send_idle = 16, recv_idle = 56;
   int errors = 0, events_sent = 0, results_seen = 0, notes_seen = 0, stalled = 0;

   // sequencer state, mirrored
   logic [15:0] m_timeout, m_now, m_half_period, m_pll, m_step_stamp, m_seen_count;
   logic [15:0] m_clock_count, m_pulse_stamp;
   logic [6:0]  m_base, m_root;
   run_type     m_run;
   logic [3:0]  m_active, m_next, m_lamps;
   logic [4:0]  m_step;
   logic        m_half, m_clear_pending, m_ext_on, m_midi_on;
   logic [2:0]  m_divider;
   logic [15:0] m_taps[3];
   logic [1:0]  m_tap_count;
   logic [7:0]  m_held[VOICES];
   logic [15:0] m_lamp_stamps[4];
   logic [7:0]  m_cells[PATTERNS][STEPS][VOICES];
   logic [6:0]  m_roots[PATTERNS];
   logic [4:0]  m_lengths[PATTERNS];
   seq_result   out_buf[$];

   function automatic logic [15:0] since(logic [15:0] stamp);
      return m_now - stamp;
   endfunction

   function automatic void emit(logic [1:0] kind, logic [6:0] note);
      seq_result r;
      if (out_buf.size() >= VOICES + 2) return;
      r.kind = kind;
      r.note = note;
      out_buf.push_back(r);
   endfunction

   function automatic void flash(int lamp);
      m_lamp_stamps[lamp] = m_now;
      m_lamps[lamp] = 1'b1;
   endfunction

   function automatic void release_all();
      emit(KIND_ALL_OFF, 0);
      foreach (m_held[v]) m_held[v] = NONE_HELD;
   endfunction

   function automatic void go_home();
      m_step = 0;
      m_half = 0;
      m_seen_count = m_clock_count;
      m_step_stamp = m_now;
   endfunction

   function automatic void clear_pattern(int pat);
      m_roots[pat] = m_base;
      m_lengths[pat] = 0;
      for (int s = 0; s < STEPS; s++)
         for (int v = 0; v < VOICES; v++) m_cells[pat][s][v] = CELL_EMPTY;
   endfunction

   function automatic void insert_cell(int pat, logic [7:0] code);
      int len;
      len = m_lengths[pat];
      if (code < CELL_EMPTY) begin
         if (len == 0) m_roots[pat] = code[6:0];
         for (int v = 0; v < VOICES; v++) begin
            if (m_cells[pat][len][v] == CELL_EMPTY) begin
               m_cells[pat][len][v] = code;
               break;
            end
         end
         return;
      end
      if (len == 0) m_roots[pat] = m_base;
      for (int v = 0; v < VOICES; v++) m_cells[pat][len][v] = code;
   endfunction

   function automatic void advance_pattern(int pat);
      release_all();
      if (m_lengths[pat] < STEPS - 1) m_lengths[pat]++;
      else begin
         m_step = 0;
         m_half = 0;
         m_run = RUN_PLAY;
      end
   endfunction

   function automatic void stop_voice(int v);
      if (!m_held[v][7]) emit(KIND_OFF, m_held[v][6:0]);
      m_held[v] = NONE_HELD;
   endfunction

   function automatic void play_tick();
      int pat, len, nxt, n;
      logic [7:0] c;
      if (m_ext_on) begin
         if (m_seen_count == m_clock_count) begin
            if (!m_half) return;
            if (since(m_step_stamp) < m_pll) return;
         end else flash(LAMP_TAP);
      end else if (m_midi_on) begin
         if (m_seen_count == m_clock_count) return;
         if (m_clock_count[0]) flash(LAMP_TAP);
      end else if (since(m_step_stamp) < m_half_period) return;
      m_step_stamp = m_now;
      m_seen_count = m_clock_count;
      if (m_run != RUN_PLAY) return;
      if (m_step == 0 && !m_half) m_active = m_next;
      pat = m_active;
      len = m_lengths[pat];
      if (len == 0) return;
      nxt = (m_step + 1) % len;
      for (int v = 0; v < VOICES; v++) begin
         c = m_cells[pat][m_step][v];
         if (c == CELL_EMPTY) stop_voice(v);
         else if (m_half) begin
            if (m_cells[pat][nxt][v] != CELL_TIE) stop_voice(v);
         end else if (c < CELL_EMPTY) begin
            n = int'(c) + int'(m_root) - int'(m_roots[pat]);
            if (n < 0) n = 0;
            if (n > 127) n = 127;
            emit(KIND_ON, 7'(n));
            m_held[v] = 8'(n);
         end
      end
      if (m_half) m_step = 5'(nxt);
      m_half = !m_half;
      if (m_half) flash(LAMP_TAP);
   endfunction

   function automatic void ms_tick();
      m_now++;
      if ((m_ext_on || m_midi_on) && since(m_step_stamp) > m_timeout) begin
         release_all();
         m_midi_on = 0;
         m_ext_on = 0;
         m_run = RUN_RESET;
      end
      if (m_lamps[0] && since(m_lamp_stamps[LAMP_PLAY]) > LAMP_HOLD_MS) m_lamps[0] = 0;
      if (m_lamps[1] && since(m_lamp_stamps[LAMP_REC]) > LAMP_HOLD_MS) m_lamps[1] = 0;
      if (m_lamps[2] && since(m_lamp_stamps[LAMP_TAP]) > LAMP_HOLD_MS) m_lamps[2] = 0;
      if (m_lamps[3] && since(m_lamp_stamps[LAMP_SAVE]) > SAVE_HOLD_MS) m_lamps[3] = 0;
      if (m_tap_count > 0 && since(m_taps[m_tap_count - 1]) >= m_timeout) m_tap_count = 0;
      play_tick();
   endfunction

   function automatic void tap_tempo();
      logic [16:0] sum;
      if (m_tap_count > 2) m_tap_count = 0;
      m_taps[m_tap_count] = m_now;
      m_tap_count++;
      if (m_tap_count != 3) return;
      m_tap_count = 0;
      sum = 17'(16'(m_taps[1] - m_taps[0])) + 17'(16'(m_taps[2] - m_taps[1]));
      m_half_period = 16'(sum >> 3);
      m_step_stamp = m_now;
   endfunction

   function automatic void reset_model();
      m_timeout = TIMEOUT_RESET;
      m_base = BASE_NOTE_RESET;
      m_now = 0; m_run = RUN_RESET; m_half_period = HALF_STEP_RESET; m_pll = 0;
      m_step_stamp = 0; m_seen_count = 0; m_active = 0; m_next = 0; m_step = 0;
      m_half = 0; m_clear_pending = 0; m_root = BASE_NOTE_RESET; m_ext_on = 0;
      m_midi_on = 0; m_clock_count = 0; m_divider = 0; m_pulse_stamp = 0;
      m_tap_count = 0; m_lamps = 0;
      foreach (m_taps[i]) m_taps[i] = 0;
      foreach (m_held[i]) m_held[i] = NONE_HELD;
      foreach (m_lamp_stamps[i]) m_lamp_stamps[i] = 0;
      for (int p = 0; p < PATTERNS; p++) clear_pattern(p);
   endfunction

   function automatic void predict_event(logic [3:0] mode, logic [6:0] note, logic [3:0] sel);
      int pat;
      logic [15:0] d;
      pat = m_active;
      out_buf.delete();
      case (mode)
         MODE_TICK: ms_tick();
         MODE_MCLK: begin
            if (!m_ext_on && m_midi_on) begin
               if (m_divider != 0) m_divider--;
               else begin
                  m_divider = MIDI_DIV_RELOAD;
                  m_clock_count++;
               end
            end
         end
         MODE_START: begin
            m_midi_on = 1; m_divider = 0; m_clock_count = 0;
            go_home();
            m_run = RUN_PLAY;
         end
         MODE_CONT: begin
            m_midi_on = 1;
            m_run = RUN_PLAY;
         end
         MODE_STOP: begin
            m_midi_on = 0;
            m_run = RUN_RESET;
            release_all();
         end
         MODE_EPULSE: begin
            if (!m_ext_on) begin
               m_pulse_stamp = m_now; m_clock_count = 1; m_ext_on = 1;
            end else begin
               d = since(m_pulse_stamp);
               if (d >= PULSE_MIN_MS) begin
                  m_pulse_stamp = m_now;
                  m_pll = d >> 1;
                  m_clock_count++;
               end
            end
         end
         MODE_ESTART: begin
            go_home();
            m_run = RUN_PLAY;
         end
         MODE_NOTE_ON: begin
            if (m_run == RUN_RESET) begin
               flash(LAMP_PLAY);
               emit(KIND_ON, note);
            end else if (m_run == RUN_PLAY) begin
               flash(LAMP_PLAY);
               m_root = note;
            end else begin
               flash(LAMP_REC);
               if (m_clear_pending) begin
                  clear_pattern(pat);
                  m_clear_pending = 0;
               end
               insert_cell(pat, {1'b0, note});
               emit(KIND_ON, note);
            end
         end
         MODE_NOTE_OFF: begin
            if (m_run == RUN_RESET) emit(KIND_OFF, note);
            else if (m_run == RUN_REC && m_cells[pat][m_lengths[pat]][0] == {1'b0, note})
               advance_pattern(pat);
         end
         MODE_SAVE: begin
            if (m_run == RUN_RESET) begin
               if (!m_lamps[3]) flash(LAMP_SAVE);
            end else if (m_run == RUN_REC) begin
               insert_cell(pat, CELL_EMPTY);
               advance_pattern(pat);
            end
         end
         MODE_TAP: begin
            if (m_run == RUN_PLAY) tap_tempo();
            else if (m_run == RUN_REC) begin
               insert_cell(pat, CELL_TIE);
               advance_pattern(pat);
            end
         end
         MODE_REC: begin
            release_all();
            if (m_run == RUN_REC) begin
               m_step = 0;
               m_run = RUN_RESET;
            end else begin
               m_step = 0;
               m_clear_pending = 1;
               m_run = RUN_REC;
            end
         end
         MODE_PLAY: begin
            release_all();
            if (m_run == RUN_PLAY) m_run = RUN_RESET;
            else begin
               m_pll = 0;
               m_step_stamp = m_now - m_half_period;
               m_seen_count = m_clock_count;
               m_step = 0;
               m_half = 0;
               m_root = m_roots[pat];
               m_run = RUN_PLAY;
            end
         end
         MODE_SELECT: begin
            m_next = sel;
            if (m_run == RUN_RESET) m_active = m_next;
         end
         default: ;
      endcase
      while (out_buf.size() >= VOICES + 2) void'(out_buf.pop_back());
      emit(KIND_STATUS, 0);
      foreach (out_buf[k]) begin
         out_buf[k].last = (k == out_buf.size() - 1);
         out_buf[k].run = m_run;
         out_buf[k].lamps = m_lamps;
         out_buf[k].queued = m_next;
         expected_results.push_back(out_buf[k]);
      end
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch at %0t on result %0d: %s got %0d expected %0d",
               $realtime, results_seen, field, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin : drive
      event_item it;
      if (reset) req_valid <= 0;
      else begin
         if (req_valid && req_ready) begin
            predict_event(req_mode, req_note_number, req_pattern_select);
            events_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_events.size() > 0 && $urandom_range(99) >= send_idle) begin
               it = pending_events.pop_front();
               req_valid <= 1;
               req_mode <= it.mode;
               req_note_number <= it.note;
               req_pattern_select <= it.sel;
            end else req_valid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // monitor
   always @(posedge clock) begin : watch
      seq_result want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected kind", rsp_event_kind, -1);
         end else begin
            want = expected_results.pop_front();
            if (want.kind == KIND_ON) notes_seen++;
            if (rsp_event_kind !== want.kind) report_mismatch("kind", rsp_event_kind, want.kind);
            if (rsp_event_note !== want.note) report_mismatch("note", rsp_event_note, want.note);
            if (rsp_last_of_run !== want.last)
               report_mismatch("last", rsp_last_of_run, want.last);
            if (rsp_run_state !== want.run) report_mismatch("run", rsp_run_state, want.run);
            if (rsp_lamp_flags !== want.lamps)
               report_mismatch("lamps", rsp_lamp_flags, want.lamps);
            if (rsp_queued_pattern !== want.queued)
               report_mismatch("queued", rsp_queued_pattern, want.queued);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) stalled <= 0;
      else stalled <= stalled + 1;
      if (stalled >= 20000) begin
         $display("timeout waiting for a transaction");
         $display("polyphonic_step_sequencer test failed");
         $finish;
      end
   end

   task automatic add(logic [3:0] mode, logic [6:0] note = 0, logic [3:0] sel = 0);
      event_item it;
      it.mode = mode;
      it.note = note;
      it.sel = sel;
      pending_events.push_back(it);
   endtask

   task automatic add_ticks(int n);
      repeat (n) add(MODE_TICK, $urandom_range(127), $urandom_range(15));
   endtask

   task automatic write_csr(csr_reg_type idx, logic [15:0] value);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 0;
      if (idx == REG_CLOCK_TIMEOUT) m_timeout = value;
      else m_base = value[6:0];
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_events.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic record_and_play(int steps);
      logic [6:0] n;
      add(MODE_STOP);
      if ($urandom_range(3) == 0) add(MODE_SELECT, 0, $urandom_range(15));
      add(MODE_REC);
      for (int s = 0; s < steps; s++) begin
         n = $urandom_range(127);
         case ($urandom_range(5))
            0, 1: begin
               add(MODE_NOTE_ON, n);
               add(MODE_NOTE_OFF, n);
            end
            2: begin
               add(MODE_NOTE_ON, n);
               add(MODE_NOTE_ON, $urandom_range(127));
               add(MODE_NOTE_OFF, n);
            end
            3: add(MODE_TAP);
            4: add(MODE_SAVE);
            default: add(MODE_NOTE_OFF, n);
         endcase
      end
      add(MODE_REC);
      add(MODE_PLAY);
      repeat (3) add(MODE_TAP);
      add_ticks($urandom_range(6, 24));
      if ($urandom_range(1)) begin
         add(MODE_NOTE_ON, $urandom_range(127));
         add_ticks($urandom_range(4, 12));
      end
      add(MODE_PLAY);
   endtask

   task automatic random_part(int target);
      int start;
      start = pending_events.size();
      while (pending_events.size() - start < target) begin
         case ($urandom_range(11))
            0, 1, 2, 3, 4: record_and_play($urandom_range(1, 6));
            5: begin
               add(MODE_START);
               repeat ($urandom_range(2, 4)) begin
                  repeat (6) add(MODE_MCLK);
                  add_ticks(1);
               end
               add(MODE_STOP);
            end
            6: begin
               add(MODE_ESTART);
               add(MODE_EPULSE);
               repeat (2) begin
                  add_ticks($urandom_range(18, 24));
                  add(MODE_EPULSE);
               end
               add_ticks(4);
            end
            7: begin
               add(MODE_STOP);
               add(MODE_REC);
               repeat (32) add($urandom_range(1) ? MODE_SAVE : MODE_TAP);
               add(MODE_PLAY);
               repeat (3) add(MODE_TAP);
               add_ticks(8);
               add(MODE_PLAY);
            end
            8: add(MODE_SELECT, $urandom_range(127), $urandom_range(15));
            default: repeat (4) add($urandom_range(15), $urandom_range(127), $urandom_range(15));
         endcase
      end
   endtask

   initial begin
      reset_model();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every mode, field extremes, note zero held and released
      add(MODE_NOTE_ON, 0);
      add(MODE_NOTE_OFF, 127);
      add(MODE_SAVE);
      add(14, 127, 15);
      add(15, 0, 0);
      add(MODE_SELECT, 127, 15);
      add(MODE_SELECT, 0, 0);
      add(MODE_REC);
      add(MODE_NOTE_ON, 0);
      add(MODE_NOTE_OFF, 0);
      add(MODE_REC);
      add(MODE_PLAY);
      repeat (3) add(MODE_TAP);
      add_ticks(4);
      add(MODE_START);
      add(MODE_MCLK);
      add(MODE_CONT);
      add(MODE_STOP);
      add(MODE_ESTART);
      add(MODE_EPULSE);
      add(MODE_PLAY);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 16 : (phase == 1) ? 56 : 0;
         recv_idle = (phase == 0) ? 56 : (phase == 1) ? 16 : 0;
         random_part(155);
         drain();
         case (phase)
            0: begin
               write_csr(REG_CLOCK_TIMEOUT, 1);
               write_csr(REG_BASE_NOTE, 127);
            end
            1: begin
               write_csr(REG_CLOCK_TIMEOUT, 16'hFFFF);
               write_csr(REG_BASE_NOTE, 0);
            end
            default: ;
         endcase
      end

      $display("covered %0d events, %0d results (%0d note-ons) over three clock/tempo setups",
               events_sent, results_seen, notes_seen);
      if (errors == 0)
         $display("polyphonic_step_sequencer test passed");
      else
         $display("polyphonic_step_sequencer test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/psseq_pkg.sv
rtl/psseq_ram.sv
rtl/psseq_front.sv
rtl/psseq_back.sv
rtl/polyphonic_step_sequencer.sv
tb/sv/tb_polyphonic_step_sequencer.sv
